FILE: hw/rtl/bavg_pkg.sv
// ---------------------------------------------------------------------------
// bavg_pkg
// types and constants shared by the box-average downscaler
// ---------------------------------------------------------------------------
`default_nettype none

package bavg_pkg;

    localparam int DIM_W  = 13;   // image sizes and positions
    localparam int PIX_W  = 8;    // one colour channel
    localparam int CH_N   = 4;    // red, green, blue, alpha
    localparam int SUM_W  = 32;   // column sum of one channel
    localparam int NUM_W  = 32;   // divider dividend and quotient
    localparam int DEN_W  = 25;   // divider divisor, box area up to 2**24
    localparam int CNT_W  = 6;    // divider step counter
    localparam int ADDR_W = 4;    // apb byte address
    localparam int DATA_W = 32;   // apb data

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_TARGET     = 2'd2,
        REG_NONE       = 2'd3
    } reg_idx_t;

    typedef logic [CH_N-1:0][SUM_W-1:0] sums_t;
    typedef logic [CH_N-1:0][PIX_W-1:0] pix_t;

endpackage

`default_nettype wire

FILE: hw/rtl/box_average_image_downscaler_unit.sv
// flow: a word that closes no box passes through S_RD and S_ADV before the input is free again;
//   a word that closes a box also passes S_CNT, four divides (one per channel) and S_EMIT
// one word at a time, taken only in S_IDLE; entering a new box adds an edge divide before the next word;
//   a single shared restoring divider does the image set-up, edge and average divides
// reset: synchronous, active low; configuration and position registers return to defaults, then an
//   image set-up of four divides (two in pass-through) runs before the first word is taken
// ---------------------------------------------------------------------------
// box_average_image_downscaler_unit
// area-average downscaler for rgba8 pixel streams with column sums in a line store
// ---------------------------------------------------------------------------
`default_nettype none

module box_average_image_downscaler_unit
    import bavg_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // apb register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    // source pixels
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [PIX_W-1:0]  s_red_in,
    input  wire logic [PIX_W-1:0]  s_green_in,
    input  wire logic [PIX_W-1:0]  s_blue_in,
    input  wire logic [PIX_W-1:0]  s_alpha_in,
    // averaged pixels
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [PIX_W-1:0]       m_red_out,
    output logic [PIX_W-1:0]       m_green_out,
    output logic [PIX_W-1:0]       m_blue_out,
    output logic [PIX_W-1:0]       m_alpha_out,
    output logic [DIM_W-2:0]       m_result_col,
    output logic [DIM_W-2:0]       m_result_row,
    output logic [DIM_W-1:0]       m_result_width,
    output logic [DIM_W-1:0]       m_result_height,
    output logic                   m_last_pixel
);

    localparam int IDX_W = $clog2(MAX_DIM);

    typedef enum logic [4:0] {
        S_INIT, S_INIT2, S_DW_RET, S_DH_RET, S_E1C_RET, S_E1R_RET,
        S_IDLE, S_RD, S_CNT, S_AVG, S_AVG_RET, S_EMIT, S_ADV,
        S_COL_MUL, S_COL_RET, S_ROW_MUL, S_ROW_RET, S_DIV
    } state_t;

    // clamp a size to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // configuration registers
    logic [DIM_W-1:0] src_width_reg, src_height_reg, target_size_reg;
    // image geometry
    logic [DIM_W-1:0] eff_w_reg, eff_h_reg, t_reg, longest_reg;
    logic [DIM_W-1:0] dest_w_reg, dest_h_reg, e1c_reg, e1r_reg;
    // stream and box position
    logic [DIM_W-1:0] in_col_reg, in_row_reg, box_col_reg, box_row_reg;
    logic [DIM_W-1:0] col_start_reg, row_start_reg, col_edge_reg, row_edge_reg;
    // current word
    pix_t             pix_reg;
    logic             first_reg, emit_reg;
    sums_t            sum_reg;
    logic [DEN_W-1:0] area_reg;
    logic [1:0]       ch_reg;
    pix_t             avg_reg;
    // shared divider
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    state_t           ret_reg;
    state_t           state_reg;
    // line store of column sums, one word holds all four channels
    sums_t            sum_mem [MAX_DIM];
    sums_t            rd_data_reg;
    logic             mem_rd;
    logic             mem_wr;
    sums_t            wr_data;
    // output register
    logic             m_valid_reg;
    pix_t             out_pix_reg;
    logic [DIM_W-2:0] out_col_reg, out_row_reg;
    logic [DIM_W-1:0] out_w_reg, out_h_reg;
    logic             out_last_reg;

    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    logic             s_acc;
    logic             out_free;
    logic             out_load;

    // divider step
    logic [DEN_W:0]   div_trial;
    logic             div_bit;
    logic [DEN_W:0]   div_diff;

    // combinational helpers
    logic [DIM_W-1:0] longest_c;
    logic [DIM_W:0]   nc_c, nr_c;
    logic [NUM_W-1:0] q_c;
    logic [DIM_W-1:0] q_dim_c;
    logic [DIM_W-1:0] q_min1_c;
    logic [2*DIM_W-1:0] area_c;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign s_ready = (state_reg == S_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    // result word loads into the output register
    assign out_load = !cfg_wr && (state_reg == S_EMIT) && out_free;

    always_comb begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = DATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = DATA_W'(src_height_reg);
            REG_TARGET:     prdata = DATA_W'(target_size_reg);
            default:        prdata = '0;
        endcase
    end

    assign div_trial = {rem_reg, num_reg[NUM_W-1]};
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign div_bit   = (div_trial >= {1'b0, den_reg});

    assign longest_c = (eff_w_reg > eff_h_reg) ? eff_w_reg : eff_h_reg;
    assign nc_c      = {1'b0, in_col_reg} + (DIM_W+1)'(1);
    assign nr_c      = {1'b0, in_row_reg} + (DIM_W+1)'(1);
    assign q_c       = num_reg;
    assign q_dim_c   = q_c[DIM_W-1:0];
    assign q_min1_c  = (q_c == '0) ? DIM_W'(1) : q_dim_c;
    assign area_c    = (2*DIM_W)'(col_edge_reg - col_start_reg)
                       * (2*DIM_W)'(row_edge_reg - row_start_reg);

    // read-modify-write of the column sums
    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            if (first_reg) begin
                wr_data[c] = SUM_W'(pix_reg[c]);
            end else begin
                wr_data[c] = rd_data_reg[c] + SUM_W'(pix_reg[c]);
            end
        end
    end

    assign mem_rd = s_acc;
    assign mem_wr = (state_reg == S_RD);

    // one read and one write port; a word's write lands before the next word is taken
    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            rd_data_reg <= sum_mem[box_col_reg[IDX_W-1:0]];
        end
        if (mem_wr) begin
            sum_mem[box_col_reg[IDX_W-1:0]] <= wr_data;
        end
    end

    // control sequencer, geometry and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_INIT;
            ret_reg         <= S_IDLE;
            src_width_reg   <= DIM_W'(1);
            src_height_reg  <= DIM_W'(1);
            target_size_reg <= DIM_W'(128);
            dest_w_reg      <= DIM_W'(1);
            dest_h_reg      <= DIM_W'(1);
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            box_col_reg     <= '0;
            box_row_reg     <= '0;
            col_start_reg   <= '0;
            row_start_reg   <= '0;
            ch_reg          <= '0;
            cnt_reg         <= '0;
            den_reg         <= DEN_W'(1);
            m_valid_reg     <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                // any write restarts the image
                unique case (cfg_idx)
                    REG_SRC_WIDTH:  src_width_reg   <= pwdata[DIM_W-1:0];
                    REG_SRC_HEIGHT: src_height_reg  <= pwdata[DIM_W-1:0];
                    REG_TARGET:     target_size_reg <= pwdata[DIM_W-1:0];
                    default:        ;
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                box_col_reg <= '0;
                box_row_reg <= '0;
                state_reg   <= S_INIT;
            end else begin
                unique case (state_reg)
                    S_INIT: begin
                        eff_w_reg     <= clamp_dim(src_width_reg);
                        eff_h_reg     <= clamp_dim(src_height_reg);
                        t_reg         <= (target_size_reg == '0) ? DIM_W'(1) : target_size_reg;
                        in_col_reg    <= '0;
                        in_row_reg    <= '0;
                        box_col_reg   <= '0;
                        box_row_reg   <= '0;
                        col_start_reg <= '0;
                        row_start_reg <= '0;
                        state_reg     <= S_INIT2;
                    end
                    S_INIT2: begin
                        longest_reg <= longest_c;
                        if (longest_c <= t_reg) begin
                            // pass-through, one pixel per box
                            dest_w_reg <= eff_w_reg;
                            dest_h_reg <= eff_h_reg;
                            num_reg    <= NUM_W'(eff_w_reg);
                            den_reg    <= DEN_W'(eff_w_reg);
                            ret_reg    <= S_E1C_RET;
                        end else begin
                            num_reg <= NUM_W'(eff_w_reg) * NUM_W'(t_reg);
                            den_reg <= DEN_W'(longest_c);
                            ret_reg <= S_DW_RET;
                        end
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(NUM_W);
                        state_reg <= S_DIV;
                    end
                    S_DW_RET: begin
                        dest_w_reg <= q_min1_c;
                        num_reg    <= NUM_W'(eff_h_reg) * NUM_W'(t_reg);
                        den_reg    <= DEN_W'(longest_reg);
                        rem_reg    <= '0;
                        cnt_reg    <= CNT_W'(NUM_W);
                        ret_reg    <= S_DH_RET;
                        state_reg  <= S_DIV;
                    end
                    S_DH_RET: begin
                        dest_h_reg <= q_min1_c;
                        num_reg    <= NUM_W'(eff_w_reg);
                        den_reg    <= DEN_W'(dest_w_reg);
                        rem_reg    <= '0;
                        cnt_reg    <= CNT_W'(NUM_W);
                        ret_reg    <= S_E1C_RET;
                        state_reg  <= S_DIV;
                    end
                    S_E1C_RET: begin
                        e1c_reg      <= q_dim_c;
                        col_edge_reg <= q_dim_c;
                        num_reg      <= NUM_W'(eff_h_reg);
                        den_reg      <= DEN_W'(dest_h_reg);
                        rem_reg      <= '0;
                        cnt_reg      <= CNT_W'(NUM_W);
                        ret_reg      <= S_E1R_RET;
                        state_reg    <= S_DIV;
                    end
                    S_E1R_RET: begin
                        e1r_reg      <= q_dim_c;
                        row_edge_reg <= q_dim_c;
                        state_reg    <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (s_acc) begin
                            pix_reg   <= {s_alpha_in, s_blue_in, s_green_in, s_red_in};
                            first_reg <= (in_row_reg == row_start_reg)
                                         && (in_col_reg == col_start_reg);
                            emit_reg  <= (nc_c == {1'b0, col_edge_reg})
                                         && (nr_c == {1'b0, row_edge_reg});
                            state_reg <= S_RD;
                        end
                    end
                    S_RD: begin
                        sum_reg   <= wr_data;
                        state_reg <= emit_reg ? S_CNT : S_ADV;
                    end
                    S_CNT: begin
                        area_reg  <= (area_c == '0) ? DEN_W'(1) : area_c[DEN_W-1:0];
                        ch_reg    <= '0;
                        state_reg <= S_AVG;
                    end
                    S_AVG: begin
                        num_reg   <= sum_reg[ch_reg];
                        den_reg   <= area_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(NUM_W);
                        ret_reg   <= S_AVG_RET;
                        state_reg <= S_DIV;
                    end
                    S_AVG_RET: begin
                        avg_reg[ch_reg] <= q_c[PIX_W-1:0];
                        ch_reg          <= ch_reg + 2'd1;
                        state_reg       <= (ch_reg == 2'(CH_N-1)) ? S_EMIT : S_AVG;
                    end
                    S_EMIT: begin
                        if (out_free) begin
                            out_pix_reg  <= avg_reg;
                            out_col_reg  <= box_col_reg[DIM_W-2:0];
                            out_row_reg  <= box_row_reg[DIM_W-2:0];
                            out_w_reg    <= dest_w_reg;
                            out_h_reg    <= dest_h_reg;
                            out_last_reg <= (box_col_reg + DIM_W'(1) == dest_w_reg)
                                            && (box_row_reg + DIM_W'(1) == dest_h_reg);
                            state_reg    <= S_ADV;
                        end
                    end
                    S_ADV: begin
                        if (nc_c >= {1'b0, eff_w_reg}) begin
                            // end of source row
                            in_col_reg    <= '0;
                            box_col_reg   <= '0;
                            col_start_reg <= '0;
                            col_edge_reg  <= e1c_reg;
                            if (nr_c >= {1'b0, eff_h_reg}) begin
                                // end of image, same settings for the next one
                                in_row_reg    <= '0;
                                box_row_reg   <= '0;
                                row_start_reg <= '0;
                                row_edge_reg  <= e1r_reg;
                                state_reg     <= S_IDLE;
                            end else if (nr_c >= {1'b0, row_edge_reg}
                                         && box_row_reg + DIM_W'(1) < dest_h_reg) begin
                                in_row_reg    <= nr_c[DIM_W-1:0];
                                box_row_reg   <= box_row_reg + DIM_W'(1);
                                row_start_reg <= row_edge_reg;
                                state_reg     <= S_ROW_MUL;
                            end else begin
                                in_row_reg <= nr_c[DIM_W-1:0];
                                state_reg  <= S_IDLE;
                            end
                        end else begin
                            in_col_reg <= nc_c[DIM_W-1:0];
                            if (nc_c >= {1'b0, col_edge_reg}
                                && box_col_reg + DIM_W'(1) < dest_w_reg) begin
                                box_col_reg   <= box_col_reg + DIM_W'(1);
                                col_start_reg <= col_edge_reg;
                                state_reg     <= S_COL_MUL;
                            end else begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    S_COL_MUL: begin
                        num_reg   <= (NUM_W'(box_col_reg) + NUM_W'(1)) * NUM_W'(eff_w_reg);
                        den_reg   <= DEN_W'(dest_w_reg);
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(NUM_W);
                        ret_reg   <= S_COL_RET;
                        state_reg <= S_DIV;
                    end
                    S_COL_RET: begin
                        col_edge_reg <= q_dim_c;
                        state_reg    <= S_IDLE;
                    end
                    S_ROW_MUL: begin
                        num_reg   <= (NUM_W'(box_row_reg) + NUM_W'(1)) * NUM_W'(eff_h_reg);
                        den_reg   <= DEN_W'(dest_h_reg);
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(NUM_W);
                        ret_reg   <= S_ROW_RET;
                        state_reg <= S_DIV;
                    end
                    S_ROW_RET: begin
                        row_edge_reg <= q_dim_c;
                        state_reg    <= S_IDLE;
                    end
                    S_DIV: begin
                        // restoring divide, one quotient bit a cycle
                        rem_reg <= div_bit ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
                        num_reg <= {num_reg[NUM_W-2:0], div_bit};
                        cnt_reg <= cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1)) begin
                            state_reg <= ret_reg;
                        end
                    end
                    default: state_reg <= S_INIT;
                endcase
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red_out       = out_pix_reg[0];
    assign m_green_out     = out_pix_reg[1];
    assign m_blue_out      = out_pix_reg[2];
    assign m_alpha_out     = out_pix_reg[3];
    assign m_result_col    = out_col_reg;
    assign m_result_row    = out_row_reg;
    assign m_result_width  = out_w_reg;
    assign m_result_height = out_h_reg;
    assign m_last_pixel    = out_last_reg;

    // box position never runs past the output size
    a_box_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (box_col_reg < dest_w_reg) && (box_row_reg < dest_h_reg))
        else $error("box position beyond output size");

    // the divider never runs with a zero divisor
    a_div_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("divide by zero");

    // a pending result is not overwritten while the output word is stalled
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && m_valid_reg && !m_ready && !cfg_wr)
        |=> (state_reg == S_EMIT))
        else $error("result loaded over a stalled word");

endmodule

`default_nettype wire
